[rtl/vfc_pkg.sv]
// Shared constants, codes and lookup functions of the voxel face culling mesher.
`default_nettype none
package vfc_pkg;

    localparam int COORD_W = 4;
    localparam int TYPE_W  = 8;
    localparam int POS_W   = 5;
    localparam int FACE_W  = 3;
    localparam int CNT_W   = 17;

    localparam logic [1:0] CMD_WRITE    = 2'd0;
    localparam logic [1:0] CMD_NEW_MESH = 2'd1;
    localparam logic [1:0] CMD_MESH     = 2'd2;

    localparam logic [FACE_W-1:0] FACE_TOP    = 3'd0;
    localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd1;
    localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd2;
    localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd3;
    localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd4;
    localparam logic [FACE_W-1:0] FACE_BACK   = 3'd5;

    localparam logic [TYPE_W-1:0] STONE_CODE = 8'd1;
    localparam logic [CNT_W-1:0]  COUNT_MAX  = 17'h1FFFF;
    localparam logic [CNT_W-1:0]  QUAD_VERTS = 17'd4;

    // Register index of air_code on the configuration port.
    localparam logic REG_AIR_CODE = 1'b0;

    // Corner offsets {dx, dy, dz} of a face; corner 0 sits in the low bits.
    function automatic logic [2:0] corner_ofs(input logic [FACE_W-1:0] face,
                                              input logic [1:0] corner);
        logic [11:0] word;
        case (face)
            FACE_TOP:    word = 12'b011_111_110_010;
            FACE_BOTTOM: word = 12'b001_101_100_000;
            FACE_LEFT:   word = 12'b001_011_010_000;
            FACE_RIGHT:  word = 12'b101_111_110_100;
            FACE_FRONT:  word = 12'b010_110_100_000;
            FACE_BACK:   word = 12'b011_111_101_001;
            default:     word = 12'b000_000_000_000;
        endcase
        return word[{corner, 1'b0} + {2'b00, corner} +: 3];
    endfunction

    // Texture corners run (0,0), (1,0), (1,1), (0,1); result is {u, v}.
    function automatic logic [1:0] tex_uv(input logic [1:0] corner);
        return {corner[1] ^ corner[0], corner[1]};
    endfunction

endpackage
`default_nettype wire

[rtl/vfc_if.sv]
// Valid/ready channel interfaces for command beats and vertex beats.
`default_nettype none
interface vfc_cmd_if;
    import vfc_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          cmd;
    logic [COORD_W-1:0]  cell_x;
    logic [COORD_W-1:0]  cell_y;
    logic [COORD_W-1:0]  cell_z;
    logic [TYPE_W-1:0]   block_type;

    modport source (output valid, cmd, cell_x, cell_y, cell_z, block_type, input ready);
    modport sink   (input valid, cmd, cell_x, cell_y, cell_z, block_type, output ready);
endinterface

interface vfc_vtx_if;
    import vfc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [FACE_W-1:0]         face_id;
    logic [POS_W-1:0]          vertex_x;
    logic [POS_W-1:0]          vertex_y;
    logic signed [POS_W-1:0]   vertex_z;
    logic                      tex_u;
    logic                      tex_v;
    logic [CNT_W-1:0]          base_index;
    logic                      last;

    modport source (output valid, face_id, vertex_x, vertex_y, vertex_z, tex_u, tex_v,
                    base_index, last, input ready);
    modport sink   (input valid, face_id, vertex_x, vertex_y, vertex_z, tex_u, tex_v,
                    base_index, last, output ready);
endinterface
`default_nettype wire

[rtl/voxel_face_cull_mesher.sv]
// Top level of the voxel face culling mesher.
// After reset the block fills every grid cell with the stone type, one cell per
// cycle, SIZE_X*SIZE_Y*SIZE_Z cells (4096 at the default size); command beats
// wait until the fill ends, while configuration writes are taken at any time. A
// write-cell or new-mesh beat leaves the sequencer idle. A mesh beat is accepted,
// then reads the cell and its six neighbors on the single grid read port, then
// emits the vertices of the visible faces, stepping over each hidden face ahead of
// the last visible one, and waits while the vertex channel stalls; the vertex output
// register lets the next command beat be taken while the final vertex waits.
`default_nettype none
module voxel_face_cull_mesher #(
    parameter int SIZE_X = 16,
    parameter int SIZE_Y = 16,
    parameter int SIZE_Z = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    vfc_cmd_if.sink          i_cmd_ch,
    vfc_vtx_if.source        o_vtx_ch
);
    import vfc_pkg::*;

    localparam int DEPTH = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int AW    = $clog2(DEPTH);

    logic [TYPE_W-1:0] w_air_code;
    logic              w_clr_busy;
    logic              w_grid_we;
    logic              w_grid_re;
    logic [AW-1:0]     w_grid_addr;
    logic [TYPE_W-1:0] w_grid_wdata;
    logic [TYPE_W-1:0] w_grid_rdata;

    vfc_apb_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_air_code (w_air_code)
    );

    vfc_grid #(
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (w_grid_we),
        .i_re       (w_grid_re),
        .i_addr     (w_grid_addr),
        .i_wdata    (w_grid_wdata),
        .o_rdata    (w_grid_rdata),
        .o_clr_busy (w_clr_busy)
    );

    vfc_seq #(
        .SIZE_X (SIZE_X),
        .SIZE_Y (SIZE_Y),
        .SIZE_Z (SIZE_Z)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_air_code   (w_air_code),
        .i_clr_busy   (w_clr_busy),
        .o_grid_we    (w_grid_we),
        .o_grid_re    (w_grid_re),
        .o_grid_addr  (w_grid_addr),
        .o_grid_wdata (w_grid_wdata),
        .i_grid_rdata (w_grid_rdata),
        .i_cmd        (i_cmd_ch),
        .o_vtx        (o_vtx_ch)
    );

    // No command beat may slip in while the stone fill still owns the grid.
    a_no_cmd_during_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_busy |-> !i_cmd_ch.ready)
        else $error("command beat accepted during grid fill");

    a_no_write_during_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_busy |-> !w_grid_we)
        else $error("grid write issued during fill");

    // The closing vertex of a cell is always the fourth corner of a quad.
    a_last_is_fourth_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vtx_ch.valid && o_vtx_ch.last) |-> (!o_vtx_ch.tex_u && o_vtx_ch.tex_v))
        else $error("last flag on a corner other than the fourth");

endmodule
`default_nettype wire

[rtl/vfc_apb_regs.sv]
// APB-style configuration register holding the air block code.
`default_nettype none
module vfc_apb_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [2:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output logic      [vfc_pkg::TYPE_W-1:0] o_air_code
);
    import vfc_pkg::*;

    logic [TYPE_W-1:0] r_air_code;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_air_code <= '0;
        end else if (w_wr && paddr[2] == REG_AIR_CODE) begin
            r_air_code <= pwdata[TYPE_W-1:0];
        end
    end

    assign prdata     = (paddr[2] == REG_AIR_CODE) ? {24'd0, r_air_code} : 32'd0;
    assign o_air_code = r_air_code;

endmodule
`default_nettype wire

[rtl/vfc_grid.sv]
// Voxel type memory with a stone fill sweep after reset.
`default_nettype none
module vfc_grid #(
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_we,
    input  wire logic                       i_re,
    input  wire logic [AW-1:0]              i_addr,
    input  wire logic [vfc_pkg::TYPE_W-1:0] i_wdata,
    output logic      [vfc_pkg::TYPE_W-1:0] o_rdata,
    output logic                            o_clr_busy
);
    import vfc_pkg::*;

    logic [TYPE_W-1:0] r_mem [DEPTH];
    logic [TYPE_W-1:0] r_rdata;
    logic              r_clr_busy;
    logic [AW-1:0]     r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // The sweep owns the write port until every cell holds stone.
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= STONE_CODE;
        end else if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clr_busy = r_clr_busy;

endmodule
`default_nettype wire

[rtl/vfc_seq.sv]
// Command sequencer: grid writes, neighbor reads, face culling and vertex output register.
`default_nettype none
module vfc_seq #(
    parameter int SIZE_X = 16,
    parameter int SIZE_Y = 16,
    parameter int SIZE_Z = 16,
    localparam int AW = $clog2(SIZE_X * SIZE_Y * SIZE_Z)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [vfc_pkg::TYPE_W-1:0] i_air_code,
    input  wire logic                       i_clr_busy,
    output logic                            o_grid_we,
    output logic                            o_grid_re,
    output logic      [AW-1:0]              o_grid_addr,
    output logic      [vfc_pkg::TYPE_W-1:0] o_grid_wdata,
    input  wire logic [vfc_pkg::TYPE_W-1:0] i_grid_rdata,
    vfc_cmd_if.sink                         i_cmd,
    vfc_vtx_if.source                       o_vtx
);
    import vfc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam logic [AW-1:0] STEP_Y = AW'(SIZE_Z);
    localparam logic [AW-1:0] STEP_X = AW'(SIZE_Y * SIZE_Z);

    logic [1:0]          r_state;
    logic [2:0]          r_idx;
    logic [AW-1:0]       r_base;
    logic [COORD_W-1:0]  r_x, r_y, r_z;
    logic [5:0]          r_nb_in;
    logic [5:0]          r_mask, n_mask;
    logic                r_center_solid;
    logic [FACE_W-1:0]   r_face;
    logic [1:0]          r_corner;
    logic [CNT_W-1:0]    r_count;

    logic                r_out_valid;
    logic [FACE_W-1:0]   r_o_face;
    logic [POS_W-1:0]    r_o_x, r_o_y;
    logic [POS_W-1:0]    r_o_z;
    logic [1:0]          r_o_uv;
    logic [CNT_W-1:0]    r_o_base;
    logic                r_o_last;

    logic                w_accept;
    logic                w_in_grid;
    logic [AW-1:0]       w_center;
    logic [AW-1:0]       w_rd_addr;
    logic                w_rd_en;
    logic [FACE_W-1:0]   w_cap_face;
    logic                w_slot_free;
    logic                w_emit;
    logic                w_last;
    logic [2:0]          w_ofs;

    assign i_cmd.ready = (r_state == S_IDLE) && !i_clr_busy;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_in_grid = (int'(i_cmd.cell_x) < SIZE_X) && (int'(i_cmd.cell_y) < SIZE_Y)
                       && (int'(i_cmd.cell_z) < SIZE_Z);
    assign w_center  = (AW'(i_cmd.cell_x) * AW'(SIZE_Y) + AW'(i_cmd.cell_y)) * AW'(SIZE_Z)
                       + AW'(i_cmd.cell_z);

    // Read slot 0 is the cell itself, slots 1 to 6 are its neighbors in face order.
    always_comb begin
        case (r_idx)
            3'd0:    w_rd_addr = r_base;
            3'd1:    w_rd_addr = r_base + STEP_Y;
            3'd2:    w_rd_addr = r_base - STEP_Y;
            3'd3:    w_rd_addr = r_base - STEP_X;
            3'd4:    w_rd_addr = r_base + STEP_X;
            3'd5:    w_rd_addr = r_base - AW'(1);
            3'd6:    w_rd_addr = r_base + AW'(1);
            default: w_rd_addr = r_base;
        endcase
    end

    assign w_rd_en = (r_state == S_READ)
                     && ((r_idx == 3'd0) || (r_idx != 3'd7 && r_nb_in[r_idx - 3'd1]));

    assign o_grid_we    = w_accept && (i_cmd.cmd == CMD_WRITE) && w_in_grid;
    assign o_grid_re    = w_rd_en;
    assign o_grid_addr  = (r_state == S_IDLE) ? w_center : w_rd_addr;
    assign o_grid_wdata = i_cmd.block_type;

    // Data read in the previous cycle decides the face two slots behind the index.
    assign w_cap_face = r_idx - 3'd2;
    always_comb begin
        n_mask = r_mask;
        if (r_state == S_READ && r_idx >= 3'd2) begin
            n_mask[w_cap_face] = !r_nb_in[w_cap_face] || (i_grid_rdata == i_air_code);
        end
    end

    assign w_slot_free = !r_out_valid || o_vtx.ready;
    assign w_emit      = (r_state == S_EMIT) && r_mask[r_face] && w_slot_free;
    assign w_last      = (r_corner == 2'd3) && ((r_mask >> (r_face + 3'd1)) == 6'd0);
    assign w_ofs       = corner_ofs(r_face, r_corner);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_vtx.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_cmd.cmd == CMD_NEW_MESH) begin
                            r_count <= '0;
                        end else if (i_cmd.cmd == CMD_MESH && w_in_grid) begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    if (r_idx == 3'd7) begin
                        r_state <= (r_center_solid && n_mask != 6'd0) ? S_EMIT : S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (w_emit && r_corner == 2'd3) begin
                        r_count <= (r_count > COUNT_MAX - QUAD_VERTS) ? COUNT_MAX
                                                                     : r_count + QUAD_VERTS;
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Item context and culling sequence; reset and loaded from the command beat in every idle cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_idx    <= '0;
            r_mask   <= '0;
            r_face   <= FACE_TOP;
            r_corner <= '0;
            r_base   <= w_center;
            r_x      <= i_cmd.cell_x;
            r_y      <= i_cmd.cell_y;
            r_z      <= i_cmd.cell_z;
            r_nb_in  <= {int'(i_cmd.cell_z) + 1 < SIZE_Z,
                         i_cmd.cell_z != '0,
                         int'(i_cmd.cell_x) + 1 < SIZE_X,
                         i_cmd.cell_x != '0,
                         i_cmd.cell_y != '0,
                         int'(i_cmd.cell_y) + 1 < SIZE_Y};
        end else if (r_state == S_READ) begin
            r_idx  <= r_idx + 3'd1;
            r_mask <= n_mask;
            if (r_idx == 3'd1) begin
                r_center_solid <= (i_grid_rdata != i_air_code);
            end
        end else if (r_state == S_EMIT) begin
            if (!r_mask[r_face]) begin
                r_face <= r_face + 3'd1;
            end else if (w_emit) begin
                r_corner <= r_corner + 2'd1;
                if (r_corner == 2'd3) begin
                    r_face <= r_face + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_face <= r_face;
            r_o_x    <= {1'b0, r_x} + {4'd0, w_ofs[2]};
            r_o_y    <= {1'b0, r_y} + {4'd0, w_ofs[1]};
            r_o_z    <= 5'd0 - ({1'b0, r_z} + {4'd0, w_ofs[0]});
            r_o_uv   <= tex_uv(r_corner);
            r_o_base <= r_count;
            r_o_last <= w_last;
        end
    end

    assign o_vtx.valid      = r_out_valid;
    assign o_vtx.face_id    = r_o_face;
    assign o_vtx.vertex_x   = r_o_x;
    assign o_vtx.vertex_y   = r_o_y;
    assign o_vtx.vertex_z   = r_o_z;
    assign o_vtx.tex_u      = r_o_uv[1];
    assign o_vtx.tex_v      = r_o_uv[0];
    assign o_vtx.base_index = r_o_base;
    assign o_vtx.last       = r_o_last;

endmodule
`default_nettype wire
